// ===== rtl/cdu_pkg.sv =====
// cdu_pkg: shared types, constants and calendar tables of the calendar date unit
// used by calendar_date_unit, cdu_alu and cdu_checker; depends on nothing
package cdu_pkg;

  // input request field widths and positions in s_axis_tdata
  localparam int DAY_W      = 5;
  localparam int MONTH_W    = 4;
  localparam int YEAR_W     = 12;
  localparam int OFFSET_W   = 16;
  localparam int IN_DAY_LSB    = 0;
  localparam int IN_MONTH_LSB  = IN_DAY_LSB + DAY_W;
  localparam int IN_YEAR_LSB   = IN_MONTH_LSB + MONTH_W;
  localparam int IN_OFFSET_LSB = IN_YEAR_LSB + YEAR_W;
  localparam int IN_BITS       = IN_OFFSET_LSB + OFFSET_W;
  localparam int IN_TDATA_W    = ((IN_BITS + 7) / 8) * 8;

  // result field widths and positions in m_axis_tdata
  localparam int WEEKDAY_W       = 3;
  localparam int OUT_OK_LSB      = 0;
  localparam int OUT_WEEKDAY_LSB = 1;
  localparam int OUT_DAY_LSB     = OUT_WEEKDAY_LSB + WEEKDAY_W;
  localparam int OUT_MONTH_LSB   = OUT_DAY_LSB + DAY_W;
  localparam int OUT_YEAR_LSB    = OUT_MONTH_LSB + MONTH_W;
  localparam int OUT_BITS        = OUT_YEAR_LSB + YEAR_W;
  localparam int OUT_TDATA_W     = ((OUT_BITS + 7) / 8) * 8;

  // calendar limits
  localparam logic [YEAR_W-1:0]  YEAR_MIN   = 12'd2000;
  localparam logic [YEAR_W-1:0]  YEAR_MAX   = 12'd2100;
  localparam logic [YEAR_W-1:0]  YEAR_C19   = 12'd1900;
  localparam logic [MONTH_W-1:0] MONTH_JAN  = 4'd1;
  localparam logic [MONTH_W-1:0] MONTH_FEB  = 4'd2;
  localparam logic [MONTH_W-1:0] MONTH_MAR  = 4'd3;
  localparam logic [MONTH_W-1:0] MONTH_APR  = 4'd4;
  localparam logic [MONTH_W-1:0] MONTH_JUN  = 4'd6;
  localparam logic [MONTH_W-1:0] MONTH_SEP  = 4'd9;
  localparam logic [MONTH_W-1:0] MONTH_NOV  = 4'd11;
  localparam logic [MONTH_W-1:0] MONTH_DEC  = 4'd12;
  localparam logic [MONTH_W-1:0] MONTH_WRAP = 4'd12;
  localparam logic [6:0]         YEAR_IN_CENT_LAST = 7'd99;

  // zeller century terms j/4 + 5j for centuries 19, 20 and 21
  localparam logic [6:0] ZC_19 = 7'd99;
  localparam logic [6:0] ZC_20 = 7'd105;
  localparam logic [6:0] ZC_21 = 7'd110;
  localparam logic [3:0] WEEK_DAYS = 4'd7;

  // status of the shared subtract unit
  typedef struct packed {
    logic borrow;  // a < b
    logic zero;    // a == b
  } alu_flags_t;

  // length of a month, 31 for codes outside 1..12
  function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                  input logic leap);
    logic [DAY_W-1:0] len;
    len = 5'd31;
    if (m == MONTH_APR || m == MONTH_JUN || m == MONTH_SEP || m == MONTH_NOV)
      len = 5'd30;
    else if (m == MONTH_FEB)
      len = leap ? 5'd29 : 5'd28;
    return len;
  endfunction

  // zeller month term floor(13 * (m + 1) / 5) for shifted months 3..14
  function automatic logic [5:0] zeller_month(input logic [MONTH_W-1:0] m);
    logic [5:0] t;
    unique case (m)
      4'd3:    t = 6'd10;
      4'd4:    t = 6'd13;
      4'd5:    t = 6'd15;
      4'd6:    t = 6'd18;
      4'd7:    t = 6'd20;
      4'd8:    t = 6'd23;
      4'd9:    t = 6'd26;
      4'd10:   t = 6'd28;
      4'd11:   t = 6'd31;
      4'd12:   t = 6'd33;
      4'd13:   t = 6'd36;
      4'd14:   t = 6'd39;
      default: t = 6'd0;
    endcase
    return t;
  endfunction

endpackage

// ===== rtl/calendar_date_unit.sv =====
// calendar_date_unit: top level, date check, zeller weekday and day addition
// depends on cdu_pkg and cdu_alu
// sequence: the request is checked, its zeller sum reduced by seven to a weekday and the
//   offset walked off month by month (about 2155 months for the largest 16-bit offset);
//   a rejected date goes from the check straight to the done state
// throughput: one request at a time; the next request is taken once the result
//   sits in the output register, even while it still waits for m_axis_tready
// reset: rst is synchronous, active high, clears the sequencer and output valid
module calendar_date_unit #(
  parameter int OFFSET_BITS = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // day_in[4:0], month_in[8:5], year_in[20:9], day_offset[36:21], zero fill
  input  logic [cdu_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // date_ok[0], weekday[3:1], day_out[8:4], month_out[12:9], year_out[24:13], zero fill
  output logic [cdu_pkg::OUT_TDATA_W-1:0]   m_axis_tdata
);

  // offset bits actually used and day counter width
  localparam int OFF_W = (OFFSET_BITS < cdu_pkg::OFFSET_W) ? OFFSET_BITS : cdu_pkg::OFFSET_W;
  localparam int DW    = OFF_W + 1;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CHECK = 3'd1;
  localparam logic [2:0] S_MOD7  = 3'd2;
  localparam logic [2:0] S_WALK  = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  logic [2:0] state;

  // captured request
  logic [cdu_pkg::DAY_W-1:0]   day_r;
  logic [cdu_pkg::MONTH_W-1:0] month_r;
  logic [cdu_pkg::YEAR_W-1:0]  year_r;
  logic [OFF_W-1:0]            off_r;

  // working registers
  logic [DW-1:0]                 d;
  logic [cdu_pkg::MONTH_W-1:0]   m;
  logic [cdu_pkg::YEAR_W-1:0]    y;
  logic [6:0]                    yr_mod100;
  logic [1:0]                    cent_mod4;
  logic [8:0]                    acc;
  logic                          ok;
  logic [cdu_pkg::WEEKDAY_W-1:0] wd;

  // output register
  logic                          out_valid;
  logic                          out_ok;
  logic [cdu_pkg::WEEKDAY_W-1:0] out_wd;
  logic [cdu_pkg::DAY_W-1:0]     out_day;
  logic [cdu_pkg::MONTH_W-1:0]   out_month;
  logic [cdu_pkg::YEAR_W-1:0]    out_year;

  // date check and zeller sum from the captured request
  logic                        in_leap;
  logic                        in_ok;
  logic                        early;
  logic [cdu_pkg::MONTH_W-1:0] zm;
  logic [cdu_pkg::YEAR_W-1:0]  zy;
  logic [cdu_pkg::YEAR_W-1:0]  zk_full;
  logic [6:0]                  zk;
  logic [6:0]                  zc;
  logic [8:0]                  zsum;

  assign in_leap = (year_r[1:0] == 2'b00) && (year_r != cdu_pkg::YEAR_MAX);
  assign in_ok   = (year_r >= cdu_pkg::YEAR_MIN) && (year_r <= cdu_pkg::YEAR_MAX) &&
                   (month_r >= cdu_pkg::MONTH_JAN) && (month_r <= cdu_pkg::MONTH_DEC) &&
                   (day_r != '0) && (day_r <= cdu_pkg::month_len(month_r, in_leap));

  assign early = (month_r < cdu_pkg::MONTH_MAR);
  assign zm    = early ? month_r + cdu_pkg::MONTH_WRAP : month_r;
  assign zy    = early ? year_r - 12'd1 : year_r;

  // century split of the shifted year, valid years only
  always_comb begin
    if (zy < cdu_pkg::YEAR_MIN) begin
      zk_full = zy - cdu_pkg::YEAR_C19;
      zc      = cdu_pkg::ZC_19;
    end else if (zy < cdu_pkg::YEAR_MAX) begin
      zk_full = zy - cdu_pkg::YEAR_MIN;
      zc      = cdu_pkg::ZC_20;
    end else begin
      zk_full = zy - cdu_pkg::YEAR_MAX;
      zc      = cdu_pkg::ZC_21;
    end
  end

  assign zk   = zk_full[6:0];
  assign zsum = 9'(day_r) + 9'(cdu_pkg::zeller_month(zm)) + 9'(zk) + 9'(zk[6:2]) + 9'(zc);

  // leap rule on the walking year
  logic                      walk_leap;
  logic [cdu_pkg::DAY_W-1:0] walk_len;

  assign walk_leap = (yr_mod100[1:0] == 2'b00) && ((yr_mod100 != '0) || (cent_mod4 == 2'b00));
  assign walk_len  = cdu_pkg::month_len(m, walk_leap);

  // shared subtractor operands
  logic [DW-1:0]       alu_a;
  logic [DW-1:0]       alu_b;
  logic [DW-1:0]       alu_diff;
  cdu_pkg::alu_flags_t alu_flags;

  assign alu_a = (state == S_MOD7) ? DW'(acc) : d;
  assign alu_b = (state == S_MOD7) ? DW'(cdu_pkg::WEEK_DAYS) : DW'(walk_len);

  cdu_alu #(.W(DW)) u_alu (
    .a     (alu_a),
    .b     (alu_b),
    .diff  (alu_diff),
    .flags (alu_flags)
  );

  assign s_axis_tready = (state == S_IDLE);
  logic out_free;
  assign out_free = !out_valid || m_axis_tready;

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE:  if (s_axis_tvalid) state <= S_CHECK;
        S_CHECK: state <= in_ok ? S_MOD7 : S_DONE;
        S_MOD7:  if (alu_flags.borrow) state <= S_WALK;
        S_WALK:  if (alu_flags.borrow || alu_flags.zero) state <= S_DONE;
        S_DONE:  if (out_free) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        if (s_axis_tvalid) begin
          day_r   <= s_axis_tdata[cdu_pkg::IN_DAY_LSB +: cdu_pkg::DAY_W];
          month_r <= s_axis_tdata[cdu_pkg::IN_MONTH_LSB +: cdu_pkg::MONTH_W];
          year_r  <= s_axis_tdata[cdu_pkg::IN_YEAR_LSB +: cdu_pkg::YEAR_W];
          off_r   <= s_axis_tdata[cdu_pkg::IN_OFFSET_LSB +: OFF_W];
        end
      end
      S_CHECK: begin
        ok  <= in_ok;
        wd  <= '0;
        acc <= zsum;
        m   <= month_r;
        y   <= year_r;
        yr_mod100 <= (year_r == cdu_pkg::YEAR_MAX) ? 7'd0 : 7'(year_r - cdu_pkg::YEAR_MIN);
        cent_mod4 <= (year_r == cdu_pkg::YEAR_MAX) ? 2'd1 : 2'd0;
        if (in_ok)
          d <= DW'(day_r) + DW'(off_r);
        else
          d <= DW'(day_r);
      end
      S_MOD7: begin
        // reduce by seven, then map saturday-based index to sunday-based
        if (!alu_flags.borrow)
          acc <= alu_diff[8:0];
        else
          wd <= (acc[2:0] == 3'd0) ? 3'd6 : acc[2:0] - 3'd1;
      end
      S_WALK: begin
        // cross one month per cycle
        if (!(alu_flags.borrow || alu_flags.zero)) begin
          d <= alu_diff;
          if (m == cdu_pkg::MONTH_DEC) begin
            m <= cdu_pkg::MONTH_JAN;
            y <= y + 12'd1;
            if (yr_mod100 == cdu_pkg::YEAR_IN_CENT_LAST) begin
              yr_mod100 <= '0;
              cent_mod4 <= cent_mod4 + 2'd1;
            end else begin
              yr_mod100 <= yr_mod100 + 7'd1;
            end
          end else begin
            m <= m + 4'd1;
          end
        end
      end
      S_DONE: ;
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_DONE && out_free) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && out_free) begin
      out_ok    <= ok;
      out_wd    <= wd;
      out_day   <= d[cdu_pkg::DAY_W-1:0];
      out_month <= m;
      out_year  <= y;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = cdu_pkg::OUT_TDATA_W'({out_year, out_month, out_day, out_wd, out_ok});

endmodule

// ===== rtl/cdu_alu.sv =====
// cdu_alu: shared subtract and compare unit of the calendar date unit
// serves both the weekday reduction and the month walk; depends on cdu_pkg
module cdu_alu #(
  parameter int W = 17
) (
  input  logic [W-1:0]        a,
  input  logic [W-1:0]        b,
  output logic [W-1:0]        diff,
  output cdu_pkg::alu_flags_t flags
);

  logic [W:0] full;

  // one wide subtract, borrow out and zero detect
  assign full         = {1'b0, a} - {1'b0, b};
  assign diff         = full[W-1:0];
  assign flags.borrow = full[W];
  assign flags.zero   = (full == '0);

endmodule

// ===== rtl/cdu_checker.sv =====
// cdu_checker: port-level checks of calendar_date_unit, attached by bind
// depends on cdu_pkg and calendar_date_unit
module cdu_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            s_axis_tvalid,
  input logic                            s_axis_tready,
  input logic [cdu_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [cdu_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);

  logic                          r_ok;
  logic [cdu_pkg::WEEKDAY_W-1:0] r_wd;
  logic [cdu_pkg::DAY_W-1:0]     r_day;
  logic [cdu_pkg::MONTH_W-1:0]   r_month;

  assign r_ok    = m_axis_tdata[cdu_pkg::OUT_OK_LSB];
  assign r_wd    = m_axis_tdata[cdu_pkg::OUT_WEEKDAY_LSB +: cdu_pkg::WEEKDAY_W];
  assign r_day   = m_axis_tdata[cdu_pkg::OUT_DAY_LSB +: cdu_pkg::DAY_W];
  assign r_month = m_axis_tdata[cdu_pkg::OUT_MONTH_LSB +: cdu_pkg::MONTH_W];

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // busy right after a request is taken
  a_busy: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("ready again right after a request");

  // rejected dates carry weekday zero
  a_bad_wd: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !r_ok |-> r_wd == '0)
    else $error("weekday nonzero on a rejected date");

  // accepted dates end on a real day and month
  a_good_date: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && r_ok |-> r_day != '0 && r_month != '0 &&
      r_month <= cdu_pkg::MONTH_DEC && r_wd <= 3'd6)
    else $error("result date or weekday out of range");

endmodule

bind calendar_date_unit cdu_checker u_cdu_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tdata  (s_axis_tdata),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

// ===== tb/cdu_scoreboard_pkg.sv =====
`timescale 1ns / 1ps
// cdu_scoreboard_pkg: expected-result tracking for the calendar date unit bench
// holds the date predictor and the result comparison; depends on cdu_pkg only
package cdu_scoreboard_pkg;

  // offset width the bench builds the unit with
  localparam int TB_OFFSET_BITS = 16;

  // one predicted result
  typedef struct {
    logic                          ok;
    logic [cdu_pkg::WEEKDAY_W-1:0] weekday;
    logic [cdu_pkg::DAY_W-1:0]     day;
    logic [cdu_pkg::MONTH_W-1:0]   month;
    logic [cdu_pkg::YEAR_W-1:0]    year;
  } date_result_t;

  class date_scoreboard;
    date_result_t pending_dates[$];
    int mismatches;
    int requests;
    int results;
    int valid_dates;

    function new();
      mismatches  = 0;
      requests    = 0;
      results     = 0;
      valid_dates = 0;
    endfunction

    // gregorian leap rule: every 4th year, except centuries not divisible by 400
    function bit leap_year(int unsigned y);
      return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
    endfunction

    function int unsigned days_in_month(int unsigned m, int unsigned y);
      if (m == cdu_pkg::MONTH_APR || m == cdu_pkg::MONTH_JUN ||
          m == cdu_pkg::MONTH_SEP || m == cdu_pkg::MONTH_NOV)
        return 30;
      if (m == cdu_pkg::MONTH_FEB)
        return leap_year(y) ? 29 : 28;
      return 31;
    endfunction

    // zeller's congruence, remapped so that 0 is sunday
    function int unsigned zeller_weekday(int unsigned d, int unsigned m, int unsigned y);
      int unsigned k;
      int unsigned j;
      int unsigned h;
      // january and february count as months 13 and 14 of the prior year
      if (m < cdu_pkg::MONTH_MAR) begin
        m = m + 12;
        y = y - 1;
      end
      k = y % 100;
      j = y / 100;
      h = (d + (13 * (m + 1)) / 5 + k + k / 4 + j / 4 + 5 * j) % 7;
      // zeller counts from saturday
      return (h + 6) % 7;
    endfunction

    // validity, weekday and the date reached after adding the offset
    function date_result_t predict_date(logic [cdu_pkg::DAY_W-1:0] d_in,
                                        logic [cdu_pkg::MONTH_W-1:0] m_in,
                                        logic [cdu_pkg::YEAR_W-1:0] y_in,
                                        logic [cdu_pkg::OFFSET_W-1:0] off);
      date_result_t r;
      int unsigned d;
      int unsigned m;
      int unsigned y;
      int unsigned len;
      int unsigned mask;
      d    = d_in;
      m    = m_in;
      y    = y_in;
      mask = (1 << TB_OFFSET_BITS) - 1;
      r.ok = (y >= cdu_pkg::YEAR_MIN) && (y <= cdu_pkg::YEAR_MAX) &&
             (m >= cdu_pkg::MONTH_JAN) && (m <= cdu_pkg::MONTH_DEC) &&
             (d >= 1) && (d <= days_in_month(m, y));
      r.weekday = '0;
      // invalid dates echo the input and ignore the offset
      if (r.ok) begin
        r.weekday = cdu_pkg::WEEKDAY_W'(zeller_weekday(d, m, y));
        d = d + (int'(off) & mask);
        len = days_in_month(m, y);
        while (d > len) begin
          d = d - len;
          m = m + 1;
          if (m > cdu_pkg::MONTH_DEC) begin
            m = cdu_pkg::MONTH_JAN;
            y = y + 1;
          end
          len = days_in_month(m, y);
        end
      end
      r.day   = cdu_pkg::DAY_W'(d);
      r.month = cdu_pkg::MONTH_W'(m);
      r.year  = cdu_pkg::YEAR_W'(y);
      return r;
    endfunction

    function void note_request(logic [cdu_pkg::DAY_W-1:0] d, logic [cdu_pkg::MONTH_W-1:0] m,
                               logic [cdu_pkg::YEAR_W-1:0] y,
                               logic [cdu_pkg::OFFSET_W-1:0] off);
      date_result_t r;
      r = predict_date(d, m, y, off);
      pending_dates.push_back(r);
      requests++;
      if (r.ok)
        valid_dates++;
    endfunction

    function void compare_field(string name, int unsigned exp_val, int unsigned act_val);
      if (exp_val != act_val) begin
        $error("%s mismatch: expected %0d, actual %0d", name, exp_val, act_val);
        mismatches++;
      end
    endfunction

    function void check_result(logic [cdu_pkg::OUT_TDATA_W-1:0] w);
      date_result_t e;
      if (pending_dates.size() == 0) begin
        $error("result with no request outstanding: tdata %h", w);
        mismatches++;
        return;
      end
      e = pending_dates.pop_front();
      results++;
      compare_field("date_ok",   e.ok,      w[cdu_pkg::OUT_OK_LSB]);
      compare_field("weekday",   e.weekday, w[cdu_pkg::OUT_WEEKDAY_LSB +: cdu_pkg::WEEKDAY_W]);
      compare_field("day_out",   e.day,     w[cdu_pkg::OUT_DAY_LSB +: cdu_pkg::DAY_W]);
      compare_field("month_out", e.month,   w[cdu_pkg::OUT_MONTH_LSB +: cdu_pkg::MONTH_W]);
      compare_field("year_out",  e.year,    w[cdu_pkg::OUT_YEAR_LSB +: cdu_pkg::YEAR_W]);
    endfunction

    function int pending();
      return pending_dates.size();
    endfunction
  endclass

endpackage

// ===== tb/calendar_date_unit_test.sv =====
`timescale 1ns / 1ps
// calendar_date_unit_test: stream bench for the calendar date unit
// drives dates and day offsets under random idling, checks each result in
// date_scoreboard; depends on cdu_pkg, cdu_scoreboard_pkg and the unit's rtl
module calendar_date_unit_test;

  localparam int CYCLE_LIMIT      = 3000000;
  localparam int DRAIN_CYCLES     = 60;
  localparam int LONG_HOLD        = 600;
  localparam int RANDOM_PER_PHASE = 82;

  logic                            clk = 1'b0;
  logic                            rst = 1'b1;
  logic                            s_axis_tvalid = 1'b0;
  logic                            s_axis_tready;
  // day_in[4:0], month_in[8:5], year_in[20:9], day_offset[36:21], zero fill
  logic [cdu_pkg::IN_TDATA_W-1:0]  s_axis_tdata = '0;
  logic                            m_axis_tvalid;
  logic                            m_axis_tready = 1'b0;
  // date_ok[0], weekday[3:1], day_out[8:4], month_out[12:9], year_out[24:13], zero fill
  logic [cdu_pkg::OUT_TDATA_W-1:0] m_axis_tdata;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_asked    = 0;
  int hold_done     = 0;
  int hold_left     = 0;
  int cycle_count   = 0;

  cdu_scoreboard_pkg::date_scoreboard sb;

  calendar_date_unit #(
    .OFFSET_BITS(cdu_scoreboard_pkg::TB_OFFSET_BITS)
  ) u_top (
    .clk(clk),
    .rst(rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
  );

  // 8 ns clock
  initial begin
    forever #4 clk = ~clk;
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // result side: check accepted results, random back-pressure, long holds on request
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready)
      sb.check_result(m_axis_tdata);
    if (hold_left > 0) begin
      hold_left     <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else if (hold_done != hold_asked) begin
      hold_done     <= hold_asked;
      hold_left     <= LONG_HOLD;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // offer one request, idling first at the sender's rate, and wait for acceptance
  task automatic send_request(input logic [cdu_pkg::DAY_W-1:0] d,
                              input logic [cdu_pkg::MONTH_W-1:0] m,
                              input logic [cdu_pkg::YEAR_W-1:0] y,
                              input logic [cdu_pkg::OFFSET_W-1:0] off);
    logic [cdu_pkg::IN_TDATA_W-1:0] word;
    word = '0;
    word[cdu_pkg::IN_DAY_LSB +: cdu_pkg::DAY_W]       = d;
    word[cdu_pkg::IN_MONTH_LSB +: cdu_pkg::MONTH_W]   = m;
    word[cdu_pkg::IN_YEAR_LSB +: cdu_pkg::YEAR_W]     = y;
    word[cdu_pkg::IN_OFFSET_LSB +: cdu_pkg::OFFSET_W] = off;
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= word;
    @(posedge clk);
    while (!s_axis_tready)
      @(posedge clk);
    sb.note_request(d, m, y, off);
  endtask

  // mostly valid dates with short offsets, some noise and some long walks
  task automatic send_random_date();
    int unsigned d;
    int unsigned m;
    int unsigned y;
    int unsigned off;
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 80) begin
      y = $urandom_range(cdu_pkg::YEAR_MAX, cdu_pkg::YEAR_MIN);
      m = $urandom_range(cdu_pkg::MONTH_DEC, cdu_pkg::MONTH_JAN);
      // month ends (leap days among them) get extra weight
      if ($urandom_range(3) == 0)
        d = sb.days_in_month(m, y);
      else
        d = $urandom_range(sb.days_in_month(m, y), 1);
    end else begin
      d = $urandom_range(31);
      m = $urandom_range(15);
      if ($urandom_range(1) == 0)
        y = $urandom_range(2110, 1990);
      else
        y = $urandom_range(4095);
    end
    pick = $urandom_range(99);
    if (pick < 70)
      off = $urandom_range(400);
    else if (pick < 90)
      off = $urandom_range(4000);
    else
      off = $urandom_range(16'hFFFF);
    send_request(cdu_pkg::DAY_W'(d), cdu_pkg::MONTH_W'(m), cdu_pkg::YEAR_W'(y),
                 cdu_pkg::OFFSET_W'(off));
  endtask

  task automatic run_phase(input int sender_pct, input int receiver_pct, input int count);
    send_idle_pct = sender_pct;
    recv_idle_pct <= receiver_pct;
    repeat (count)
      send_random_date();
  endtask

  // stimulus
  initial begin
    sb = new();
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    send_idle_pct = 20;
    recv_idle_pct <= 60;

    // range limits of the valid calendar
    send_request(5'd1,  4'd1,  cdu_pkg::YEAR_MIN, 16'd0);
    send_request(5'd31, 4'd12, cdu_pkg::YEAR_MAX, 16'd0);
    send_request(5'd31, 4'd12, cdu_pkg::YEAR_MAX, 16'hFFFF);
    send_request(5'd1,  4'd1,  cdu_pkg::YEAR_MIN, 16'h8000);
    // leap rule: 400-year century, plain 4-year, non-leap century, common year
    send_request(5'd29, 4'd2,  cdu_pkg::YEAR_MIN, 16'd1);
    send_request(5'd29, 4'd2,  12'd2004, 16'd365);
    send_request(5'd29, 4'd2,  cdu_pkg::YEAR_MAX, 16'd3);
    send_request(5'd29, 4'd2,  12'd2001, 16'd3);
    send_request(5'd28, 4'd2,  cdu_pkg::YEAR_MAX, 16'd1);
    send_request(5'd31, 4'd1,  12'd2024, 16'd29);
    // day bounds
    send_request(5'd0,  4'd5,  12'd2020, 16'd10);
    send_request(5'd31, 4'd4,  12'd2020, 16'd10);
    send_request(5'd30, 4'd4,  12'd2020, 16'd1);
    // month codes outside 1..12
    send_request(5'd1,  4'd0,  12'd2020, 16'd7);
    send_request(5'd1,  4'd13, 12'd2020, 16'd7);
    send_request(5'd31, 4'd15, 12'd4095, 16'hFFFF);
    // years just outside the range and the field extremes
    send_request(5'd31, 4'd12, 12'd1999, 16'd1);
    send_request(5'd1,  4'd1,  12'd2101, 16'd1);
    send_request(5'd0,  4'd0,  12'd0,    16'd0);
    // year rollover and offset bit patterns
    send_request(5'd31, 4'd12, 12'd2099, 16'd1);
    send_request(5'd15, 4'd6,  12'd2050, 16'h5555);
    send_request(5'd15, 4'd6,  12'd2050, 16'h2AAA);
    send_request(5'd1,  4'd3,  cdu_pkg::YEAR_MIN, 16'd0);

    repeat (RANDOM_PER_PHASE)
      send_random_date();
    run_phase(60, 20, RANDOM_PER_PHASE);
    // long receiver hold while requests keep coming
    hold_asked <= hold_asked + 1;
    run_phase(0, 0, RANDOM_PER_PHASE);
    s_axis_tvalid <= 1'b0;

    while (sb.pending() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("run covered %0d requests (%0d valid dates), %0d results compared, %0d mismatches",
             sb.requests, sb.valid_dates, sb.results, sb.mismatches);
    if (sb.mismatches == 0 && sb.pending() == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule
